// ===== rtl/bwpe_pkg.sv =====
// shared types, constants and functions of the warp polynomial evaluator
package bwpe_pkg;

	localparam int MAX_TERMS_DEF = 45;
	localparam int TAB_TERMS     = 45;
	localparam int NUM_TIERS     = 11;
	localparam int FRAC          = 17;
	localparam int MAX_POW       = 8;
	localparam int POW_AW        = $clog2(MAX_POW + 1);
	localparam int XW            = 18;
	localparam int PW            = XW + 1;
	localparam int PROD_W        = 2 * PW;
	localparam int COEF_W        = 32;
	localparam int TERM_W        = COEF_W + PW;
	localparam int ACC_W         = TERM_W + 6;
	localparam int VAL_W         = 48;
	localparam int IDX_W         = 6;
	localparam int TC_W          = 6;
	localparam int PDATA_W       = 32;
	localparam int PADDR_W       = 3;

	localparam logic signed [PW-1:0]     POW_ONE   = PW'(1 << FRAC);
	localparam logic signed [PROD_W-1:0] POW_HALF  = PROD_W'(1 << (FRAC - 1));
	localparam logic signed [63:0]       VAL_MAX   = 64'sd140737488355327;
	localparam logic signed [63:0]       VAL_MIN   = -64'sd140737488355328;
	localparam logic [5:0]               TC_RESET  = 6'd45;

	// register index, taken from paddr bit 2
	localparam logic REG_TERM_COUNT = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW,
		ST_TERM,
		ST_DRAIN,
		ST_DONE
	} bwpe_state_t;

	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctl_t;

	localparam logic [IDX_W-1:0] TIER_END [NUM_TIERS] = '{
		6'd3, 6'd6, 6'd10, 6'd15, 6'd19, 6'd22, 6'd25, 6'd27, 6'd31, 6'd37, 6'd45
	};

	localparam logic [POW_AW-1:0] XPOW_TAB [TAB_TERMS] = '{
		4'd0, 4'd1, 4'd0, 4'd2, 4'd1, 4'd0, 4'd3, 4'd2, 4'd1, 4'd0, 4'd4, 4'd3,
		4'd2, 4'd1, 4'd0, 4'd4, 4'd3, 4'd2, 4'd1, 4'd4, 4'd3, 4'd2, 4'd4, 4'd3,
		4'd4, 4'd5, 4'd0, 4'd6, 4'd5, 4'd0, 4'd1, 4'd7, 4'd6, 4'd5, 4'd2, 4'd1,
		4'd0, 4'd8, 4'd7, 4'd6, 4'd5, 4'd0, 4'd1, 4'd2, 4'd3
	};

	localparam logic [POW_AW-1:0] YPOW_TAB [TAB_TERMS] = '{
		4'd0, 4'd0, 4'd1, 4'd0, 4'd1, 4'd2, 4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1,
		4'd2, 4'd3, 4'd4, 4'd1, 4'd2, 4'd3, 4'd4, 4'd2, 4'd3, 4'd4, 4'd3, 4'd4,
		4'd4, 4'd0, 4'd5, 4'd0, 4'd1, 4'd6, 4'd5, 4'd0, 4'd1, 4'd2, 4'd5, 4'd6,
		4'd7, 4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd7, 4'd6, 4'd5
	};

	function automatic logic [POW_AW-1:0] xpow_of(input logic [IDX_W-1:0] idx);
		logic [POW_AW-1:0] r;
		r = '0;
		if (int'(idx) < TAB_TERMS) begin
			r = XPOW_TAB[idx];
		end
		return r;
	endfunction

	function automatic logic [POW_AW-1:0] ypow_of(input logic [IDX_W-1:0] idx);
		logic [POW_AW-1:0] r;
		r = '0;
		if (int'(idx) < TAB_TERMS) begin
			r = YPOW_TAB[idx];
		end
		return r;
	endfunction

	// largest tier end covered by the term count and the store depth
	function automatic logic [IDX_W-1:0] tier_limit(input logic [TC_W-1:0] tc,
			input int max_terms);
		logic [IDX_W-1:0] lim;
		lim = '0;
		for (int i = 0; i < NUM_TIERS; i++) begin
			if (tc >= TIER_END[i] && int'(TIER_END[i]) <= max_terms) begin
				lim = TIER_END[i];
			end
		end
		return lim;
	endfunction

	// round half up and drop the fraction of a Q1.17 by Q1.17 product
	function automatic logic signed [PW-1:0] rnd_pow(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + POW_HALF;
		return t[FRAC+PW-1:FRAC];
	endfunction

endpackage

// ===== rtl/bwpe_ifs.sv =====
// request and result channel interfaces
interface bwpe_item_if;
	import bwpe_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [IDX_W-1:0]         coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic signed [XW-1:0]     x_offset;
	logic signed [XW-1:0]     y_offset;

	modport source(output valid, action, coef_index, coef_value, x_offset, y_offset,
		input ready);
	modport sink(input valid, action, coef_index, coef_value, x_offset, y_offset,
		output ready);
endinterface

interface bwpe_result_if;
	import bwpe_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value;
	logic                    saturated;

	modport source(output valid, value, saturated, input ready);
	modport sink(input valid, value, saturated, output ready);
endinterface

// ===== rtl/bwpe_ram.sv =====
// generic single write, single read ram with registered read data
module bwpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 45
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bwpe_pow.sv =====
// power tables of x and y, built one power a cycle by a shared multiplier pair
module bwpe_pow (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [bwpe_pkg::XW-1:0]   x,
	input  logic signed [bwpe_pkg::XW-1:0]   y,
	input  logic [bwpe_pkg::POW_AW-1:0]      rd_xp,
	input  logic [bwpe_pkg::POW_AW-1:0]      rd_yp,
	output logic                             busy,
	output logic signed [bwpe_pkg::PW-1:0]   px_rd,
	output logic signed [bwpe_pkg::PW-1:0]   py_rd
);
	import bwpe_pkg::*;

	logic signed [PW-1:0]     px_q [MAX_POW+1];
	logic signed [PW-1:0]     py_q [MAX_POW+1];
	logic signed [PW-1:0]     cur_x_q, cur_y_q;
	logic signed [XW-1:0]     x_q, y_q;
	logic [POW_AW-1:0]        cnt_q;
	logic                     busy_q;
	logic signed [PW-1:0]     sx, sy, nx, ny;
	logic signed [PROD_W-1:0] prod_x, prod_y;

	assign sx     = PW'(x_q);
	assign sy     = PW'(y_q);
	assign prod_x = cur_x_q * sx;
	assign prod_y = cur_y_q * sy;
	assign nx     = rnd_pow(prod_x);
	assign ny     = rnd_pow(prod_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= POW_AW'(1);
		end else if (busy_q) begin
			cnt_q <= cnt_q + POW_AW'(1);
			if (cnt_q == POW_AW'(MAX_POW)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			px_q[0] <= POW_ONE;
			py_q[0] <= POW_ONE;
			cur_x_q <= POW_ONE;
			cur_y_q <= POW_ONE;
			x_q     <= x;
			y_q     <= y;
		end else if (busy_q) begin
			px_q[cnt_q] <= nx;
			py_q[cnt_q] <= ny;
			cur_x_q     <= nx;
			cur_y_q     <= ny;
		end
	end

	assign busy  = busy_q;
	assign px_rd = px_q[rd_xp];
	assign py_rd = py_q[rd_yp];
endmodule

// ===== rtl/bwpe_mac.sv =====
// monomial, coefficient product and exact accumulation pipeline
module bwpe_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bwpe_pkg::mac_ctl_t                  ctl,
	input  logic signed [bwpe_pkg::PW-1:0]      px,
	input  logic signed [bwpe_pkg::PW-1:0]      py,
	input  logic signed [bwpe_pkg::COEF_W-1:0]  coef,
	output logic                                busy,
	output logic signed [bwpe_pkg::ACC_W-1:0]   acc
);
	import bwpe_pkg::*;

	logic                     v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0] mono_s1;
	logic signed [PW-1:0]     m_s2;
	logic signed [COEF_W-1:0] coef_s2;
	logic signed [TERM_W-1:0] term_s3;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (v_s3) begin
				acc_q <= acc_q + ACC_W'(term_s3);
			end
		end
	end

	// coef arrives from the ram in the cycle after the issue, next to mono_s1
	always_ff @(posedge clk) begin
		mono_s1 <= px * py;
		if (v_s1) begin
			m_s2    <= rnd_pow(mono_s1);
			coef_s2 <= coef;
		end
		if (v_s2) begin
			term_s3 <= coef_s2 * m_s2;
		end
	end

	assign busy = v_s1 | v_s2 | v_s3;
	assign acc  = acc_q;
endmodule

// ===== rtl/bivariate_warp_polynomial_eval.sv =====
// an evaluate request passes through the power steps, one term issue per term up to the
// tier limit, the mac drain and the result load; one evaluate at a time, set by the shared
// power multipliers and the single term multiply-accumulate walking the coefficient ram
// loads are taken while idle; the result register lets a request in while it waits
// reset clears control and sets term_count to 45; coefficient ram is not cleared
module bivariate_warp_polynomial_eval #(
	parameter int MAX_TERMS = bwpe_pkg::MAX_TERMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bwpe_item_if.sink                         item,
	bwpe_result_if.source                     result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bwpe_pkg::PADDR_W-1:0]      paddr,
	input  logic [bwpe_pkg::PDATA_W-1:0]      pwdata,
	output logic [bwpe_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import bwpe_pkg::*;

	localparam int AW = $clog2(MAX_TERMS);
	localparam int CW = $clog2(MAX_TERMS + 1);

	bwpe_state_t          state_q, state_d;
	logic [TC_W-1:0]      term_count_q;
	logic [CW-1:0]        lim_q, cnt_q;
	logic                 out_valid_q, sat_q;
	logic signed [VAL_W-1:0] value_q;

	logic                 accept, pow_start, ram_we, out_load, issue;
	mac_ctl_t             mac_ctl;
	logic                 pow_busy, mac_busy;
	logic [COEF_W-1:0]    ram_rdata;
	logic signed [PW-1:0] px_rd, py_rd;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W:0]   acc_r;
	logic signed [ACC_W-FRAC:0] res;
	logic signed [63:0]   res64;
	logic signed [VAL_W-1:0] res_val;
	logic                 res_sat;
	logic [IDX_W-1:0]     term_idx;

	// configuration port
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TC_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TERM_COUNT) begin
			term_count_q <= pwdata[TC_W-1:0];
		end
	end
	assign prdata = (paddr[2] == REG_TERM_COUNT) ? PDATA_W'(term_count_q) : '0;

	assign accept   = item.valid && item.ready;
	assign term_idx = IDX_W'(cnt_q);

	always_comb begin
		state_d     = state_q;
		item.ready  = 1'b0;
		pow_start   = 1'b0;
		ram_we      = 1'b0;
		issue       = 1'b0;
		out_load    = 1'b0;
		mac_ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					if (item.action) begin
						pow_start     = 1'b1;
						mac_ctl.clear = 1'b1;
						state_d       = ST_POW;
					end else if (item.coef_index < IDX_W'(MAX_TERMS)) begin
						ram_we = 1'b1;
					end
				end
			end
			ST_POW: begin
				if (!pow_busy) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				if (cnt_q < lim_q) begin
					issue         = 1'b1;
					mac_ctl.issue = 1'b1;
				end else begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!mac_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			lim_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pow_start) begin
				cnt_q <= '0;
				lim_q <= CW'(tier_limit(term_count_q, MAX_TERMS));
			end else if (issue) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// final rounding to Q32.16 and clip to the 48-bit range
	assign acc_r = (ACC_W+1)'(acc) + (ACC_W+1)'(1 << (FRAC - 1));
	assign res   = acc_r[ACC_W:FRAC];
	assign res64 = 64'(res);
	always_comb begin
		res_sat = 1'b0;
		res_val = res64[VAL_W-1:0];
		if (res64 > VAL_MAX) begin
			res_sat = 1'b1;
			res_val = VAL_MAX[VAL_W-1:0];
		end else if (res64 < VAL_MIN) begin
			res_sat = 1'b1;
			res_val = VAL_MIN[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= res_val;
			sat_q   <= res_sat;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.value     = value_q;
	assign result.saturated = sat_q;

	bwpe_ram #(
		.WIDTH(COEF_W),
		.DEPTH(MAX_TERMS)
	) u_coef_ram (
		.clk  (clk),
		.we   (ram_we && accept),
		.waddr(item.coef_index[AW-1:0]),
		.wdata(item.coef_value),
		.raddr(cnt_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	bwpe_pow u_pow (
		.clk   (clk),
		.arst_n(arst_n),
		.start (pow_start),
		.x     (item.x_offset),
		.y     (item.y_offset),
		.rd_xp (xpow_of(term_idx)),
		.rd_yp (ypow_of(term_idx)),
		.busy  (pow_busy),
		.px_rd (px_rd),
		.py_rd (py_rd)
	);

	bwpe_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.px    (px_rd),
		.py    (py_rd),
		.coef  (ram_rdata),
		.busy  (mac_busy),
		.acc   (acc)
	);
endmodule

// ===== bench/bivariate_warp_polynomial_eval_test.sv =====
// self-checking testbench of the warp polynomial evaluator: coefficient loads, evaluates, term count
module bivariate_warp_polynomial_eval_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bwpe_pkg::*;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EVAL = 1'b1;
	localparam logic [PADDR_W-1:0] ADDR_TERM_COUNT = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_SPARE      = 3'd4;

	localparam int STORE_DEPTH    = 45;
	localparam int IDLE_PCT       = 31;
	localparam int HOLD_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES         = 18;
	localparam int PHASE_ITEMS    = 100;
	localparam int NO_STALL_PHASE = 5;
	localparam int PAUSE_PHASE    = 8;

	localparam logic signed [XW-1:0]     COORD_MIN = 18'sh20000;
	localparam logic signed [XW-1:0]     COORD_MAX = 18'sh1ffff;
	localparam logic signed [COEF_W-1:0] COEF_MAX  = 32'sh7fffffff;
	localparam logic signed [COEF_W-1:0] COEF_MIN  = 32'sh80000000;
	localparam longint                   SUM_MAX   = 64'sd140737488355327;

	localparam int TIER_ENDS [11] = '{3, 6, 10, 15, 19, 22, 25, 27, 31, 37, 45};
	localparam int X_POW [45] = '{
		0, 1, 0, 2, 1, 0, 3, 2, 1, 0, 4, 3, 2, 1, 0, 4, 3, 2, 1, 4, 3, 2, 4,
		3, 4, 5, 0, 6, 5, 0, 1, 7, 6, 5, 2, 1, 0, 8, 7, 6, 5, 0, 1, 2, 3};
	localparam int Y_POW [45] = '{
		0, 0, 1, 0, 1, 2, 0, 1, 2, 3, 0, 1, 2, 3, 4, 1, 2, 3, 4, 2, 3, 4, 3,
		4, 4, 0, 5, 0, 1, 6, 5, 0, 1, 2, 5, 6, 7, 0, 1, 2, 3, 8, 7, 6, 5};
	localparam int PHASE_TCS [16] = '{45, 0, 63, 3, 2, 44, 46, 6, 10, 15, 19, 22, 25, 27, 31, 37};

	typedef struct {
		logic                     action;
		logic [IDX_W-1:0]         coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [XW-1:0]     x_offset;
		logic signed [XW-1:0]     y_offset;
	} warp_req_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    saturated;
	} warp_res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	bwpe_item_if   item_bus ();
	bwpe_result_if result_bus ();

	bivariate_warp_polynomial_eval dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (result_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic signed [COEF_W-1:0] coef_shadow [STORE_DEPTH];
	logic [TC_W-1:0]          term_count_shadow;
	warp_res_t                expected_warp_q [$];
	warp_res_t                head_result;

	bit no_stall;
	int errors;
	int idle_cycles;
	int loads_sent, evals_sent, results_checked, settings_written;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint round_q17(input longint v);
		return (v + 64'sd65536) >>> 17;
	endfunction

	function automatic warp_res_t predict_warp(input logic signed [XW-1:0] x,
			input logic signed [XW-1:0] y);
		longint xp [9];
		longint yp [9];
		longint acc, mono, sum;
		int limit;
		warp_res_t r;
		limit = 0;
		for (int t = 0; t < 11; t++) begin
			if (int'(term_count_shadow) >= TIER_ENDS[t]) begin
				limit = TIER_ENDS[t];
			end
		end
		xp[0] = 64'sd131072;
		yp[0] = 64'sd131072;
		for (int k = 1; k <= 8; k++) begin
			xp[k] = round_q17(xp[k-1] * longint'(x));
			yp[k] = round_q17(yp[k-1] * longint'(y));
		end
		acc = 0;
		for (int k = 0; k < limit; k++) begin
			mono = round_q17(xp[X_POW[k]] * yp[Y_POW[k]]);
			acc += longint'(coef_shadow[k]) * mono;
		end
		sum = round_q17(acc);
		r.saturated = 1'b0;
		if (sum > SUM_MAX) begin
			sum = SUM_MAX;
			r.saturated = 1'b1;
		end else if (sum < -SUM_MAX - 1) begin
			sum = -SUM_MAX - 1;
			r.saturated = 1'b1;
		end
		r.value = sum[VAL_W-1:0];
		return r;
	endfunction

	function automatic logic signed [XW-1:0] random_coord();
		int s;
		s = $urandom_range(0, 8) - 4;
		case ($urandom_range(0, 7))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return XW'(s);
			3: return COORD_MAX - XW'($urandom_range(0, 255));
			default: return XW'($urandom());
		endcase
	endfunction

	function automatic logic signed [COEF_W-1:0] random_coef();
		int s;
		s = $urandom_range(0, 512) - 256;
		case ($urandom_range(0, 7))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			3: return COEF_W'(s);
			default: return COEF_W'($urandom());
		endcase
	endfunction

	task automatic send_request(input warp_req_t r);
		if (!no_stall && $urandom_range(0, 99) < IDLE_PCT) begin
			item_bus.valid <= 1'b0;
			do @(posedge clk); while (!no_stall && $urandom_range(0, 99) < IDLE_PCT);
		end
		item_bus.valid      <= 1'b1;
		item_bus.action     <= r.action;
		item_bus.coef_index <= r.coef_index;
		item_bus.coef_value <= r.coef_value;
		item_bus.x_offset   <= r.x_offset;
		item_bus.y_offset   <= r.y_offset;
		do @(posedge clk); while (!item_bus.ready);
		if (r.action == ACT_EVAL) begin
			expected_warp_q.push_back(predict_warp(r.x_offset, r.y_offset));
			evals_sent++;
		end else begin
			// loads past the store depth are dropped by the block
			if (int'(r.coef_index) < STORE_DEPTH) begin
				coef_shadow[r.coef_index] = r.coef_value;
			end
			loads_sent++;
		end
	endtask

	task automatic send_load(input int idx, input logic signed [COEF_W-1:0] val);
		warp_req_t r;
		r.action     = ACT_LOAD;
		r.coef_index = IDX_W'(idx);
		r.coef_value = val;
		r.x_offset   = XW'($urandom());
		r.y_offset   = XW'($urandom());
		send_request(r);
	endtask

	task automatic send_eval(input logic signed [XW-1:0] x, input logic signed [XW-1:0] y);
		warp_req_t r;
		r.action     = ACT_EVAL;
		r.coef_index = IDX_W'($urandom());
		r.coef_value = COEF_W'($urandom());
		r.x_offset   = x;
		r.y_offset   = y;
		send_request(r);
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// block must be idle: no result owed and any trailing load retired
	task automatic wait_idle();
		item_bus.valid <= 1'b0;
		@(posedge clk);
		while (expected_warp_q.size() != 0) @(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic set_term_count(input logic [TC_W-1:0] tc);
		logic [PDATA_W-1:0] data;
		wait_idle();
		// upper bits are not part of the register
		data = $urandom();
		data[TC_W-1:0] = tc;
		reg_write(ADDR_TERM_COUNT, data);
		term_count_shadow = tc;
		settings_written++;
	endtask

	task automatic test_register_access();
		logic [PDATA_W-1:0] rd;
		reg_read(ADDR_TERM_COUNT, rd);
		if (rd !== PDATA_W'(TC_RESET)) begin
			$error("term_count after reset: expected %0d, got %0d", TC_RESET, rd);
			errors++;
		end
		set_term_count(6'd10);
		reg_read(ADDR_TERM_COUNT, rd);
		if (rd !== PDATA_W'(term_count_shadow)) begin
			$error("term_count: expected %0d, got %0d", term_count_shadow, rd);
			errors++;
		end
		// a write to an unmapped address must leave term_count alone
		reg_write(ADDR_SPARE, 32'h0000_0003);
		reg_read(ADDR_TERM_COUNT, rd);
		if (rd !== PDATA_W'(term_count_shadow)) begin
			$error("term_count: expected %0d, got %0d", term_count_shadow, rd);
			errors++;
		end
	endtask

	task automatic test_short_polynomial();
		// below the first tier nothing is read from the store
		set_term_count(6'd0);
		send_eval(COORD_MAX, COORD_MIN);
		set_term_count(6'd2);
		send_eval(COORD_MIN, COORD_MAX);
	endtask

	task automatic test_coefficient_load();
		send_load(0, COEF_MAX);
		send_load(1, COEF_MIN);
		send_load(2, COEF_MAX);
		send_load(45, COEF_MIN);
		send_load(63, COEF_MIN);
		set_term_count(6'd3);
		send_eval(COORD_MIN, COORD_MIN);
		send_eval(COORD_MAX, COORD_MAX);
		send_eval(COORD_MIN, COORD_MAX);
		send_eval('0, '0);
		send_eval(18'sd1, -18'sd1);
		send_load(1, '0);
		send_load(2, -32'sd1);
		send_eval(COORD_MAX, COORD_MIN);
		set_term_count(6'd5);
		send_eval(COORD_MIN, COORD_MIN);
	endtask

	task automatic test_random_warp();
		int p, n;
		logic [TC_W-1:0] tc;
		for (int k = 0; k < STORE_DEPTH; k++) begin
			send_load(k, random_coef());
		end
		for (p = 0; p < PHASES; p++) begin
			tc = (p < 16) ? TC_W'(PHASE_TCS[p]) : TC_W'($urandom_range(0, 63));
			set_term_count(tc);
			no_stall = (p == NO_STALL_PHASE);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (p == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
					item_bus.valid <= 1'b0;
					@(posedge clk);
					while (expected_warp_q.size() != 0) @(posedge clk);
				end
				if ($urandom_range(0, 99) < 35) begin
					if ($urandom_range(0, 9) == 0) begin
						send_load($urandom_range(STORE_DEPTH, 63), random_coef());
					end else begin
						send_load($urandom_range(0, STORE_DEPTH - 1), random_coef());
					end
				end else begin
					send_eval(random_coord(), random_coord());
				end
			end
			no_stall = 1'b0;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (result_bus.valid && result_bus.ready) begin
				if (expected_warp_q.size() == 0) begin
					$error("result with no evaluate pending: value %0d", result_bus.value);
					errors++;
				end else begin
					head_result = expected_warp_q.pop_front();
					results_checked++;
					if (result_bus.value !== head_result.value) begin
						$error("value: expected %0d, got %0d", head_result.value,
							result_bus.value);
						errors++;
					end
					if (result_bus.saturated !== head_result.saturated) begin
						$error("saturated: expected %0d, got %0d", head_result.saturated,
							result_bus.saturated);
						errors++;
					end
				end
			end
			result_bus.ready <= no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[bivariate_warp_polynomial_eval] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		item_bus.valid      = 1'b0;
		item_bus.action     = ACT_LOAD;
		item_bus.coef_index = '0;
		item_bus.coef_value = '0;
		item_bus.x_offset   = '0;
		item_bus.y_offset   = '0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		no_stall            = 1'b0;
		errors              = 0;
		term_count_shadow   = TC_RESET;
		for (int k = 0; k < STORE_DEPTH; k++) begin
			coef_shadow[k] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_short_polynomial();
		test_coefficient_load();
		test_random_warp();
		item_bus.valid <= 1'b0;
		while (expected_warp_q.size() != 0) @(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
		$display("sent %0d requests: %0d coefficient loads, %0d evaluates, %0d results checked",
			loads_sent + evals_sent, loads_sent, evals_sent, results_checked);
		$display("term count rewritten %0d times, from 0 to 63 through every tier end",
			settings_written);
		if (errors == 0) begin
			$display("[bivariate_warp_polynomial_eval] OK");
		end else begin
			$display("[bivariate_warp_polynomial_eval] ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bwpe_pkg.sv
rtl/bwpe_ifs.sv
rtl/bwpe_ram.sv
rtl/bwpe_pow.sv
rtl/bwpe_mac.sv
rtl/bivariate_warp_polynomial_eval.sv
bench/bivariate_warp_polynomial_eval_test.sv
